/* sv/crcdfr_pkg.sv */
// Package for the CRC-8 packet deframer: payload widths, result status codes,
// controller/datapath command and status structs, and the CRC-8 byte update.
// No dependencies.
package crcdfr_pkg;

  localparam int BYTE_W   = 8;
  localparam int STAT_W   = 2;
  localparam int CODE_W   = 2;
  localparam int WCNT_W   = 5;    // word_count / word_index field width
  localparam int WORD_W   = 16;
  localparam int PKT_W    = 32;
  localparam int HCNT_W   = 6;    // count field of the header byte
  localparam int BPOS_W   = HCNT_W + 1;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_GOOD     = 2'd0;
  localparam logic [STAT_W-1:0] ST_CRC_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_CNT_OVER = 2'd2;

  // One result item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CODE_W-1:0] op_code;
    logic [BYTE_W-1:0] page_number;
    logic [BYTE_W-1:0] start_offset;
    logic [WCNT_W-1:0] word_count;
    logic [WCNT_W-1:0] word_index;
    logic [WORD_W-1:0] word_value;
    logic              has_word;
    logic              last;
    logic [PKT_W-1:0]  good_packets;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic ld_hdr;        // accept header byte, start CRC
    logic ld_chk;        // capture checksum byte
    logic ld_page;       // capture page byte
    logic ld_off;        // capture offset byte
    logic ld_data;       // data byte into word store
    logic emit_hdr_err;  // count above limit result
    logic emit_crc_err;  // checksum mismatch result
    logic emit_empty;    // good header-only result
    logic cnt_inc;       // good packet seen
    logic rd_start;      // first word of a good packet
    logic idx_inc;       // next word
    logic emit_word;     // word result from read data
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_over;   // header count above limit
    logic cnt_zero;   // held count is zero
    logic data_done;  // current data byte closes the packet
    logic crc_bad;    // CRC including current byte differs from checksum
    logic emit_last;  // current word is the last of the packet
    logic out_free;   // output register can take a result this cycle
  } sts_t;

  // CRC-8, MSB first, one byte
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/crcdfr_if.sv */
// Channel interfaces of the deframer: received byte stream and result stream.
// Depends on crcdfr_pkg.
interface crcdfr_byte_if
  import crcdfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcdfr_res_if
  import crcdfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CODE_W-1:0] op_code;
  logic [BYTE_W-1:0] page_number;
  logic [BYTE_W-1:0] start_offset;
  logic [WCNT_W-1:0] word_count;
  logic [WCNT_W-1:0] word_index;
  logic [WORD_W-1:0] word_value;
  logic              has_word;
  logic              last;
  logic [PKT_W-1:0]  good_packets;

  modport source (output valid, output status, output op_code, output page_number,
                  output start_offset, output word_count, output word_index,
                  output word_value, output has_word, output last,
                  output good_packets, input ready);
  modport sink   (input valid, input status, input op_code, input page_number,
                  input start_offset, input word_count, input word_index,
                  input word_value, input has_word, input last,
                  input good_packets, output ready);
endinterface

/* sv/crc8_register_packet_deframer.sv */
// CRC-8 register packet deframer, top level: controller plus datapath.
// An error or header-only result is valid the cycle after its closing byte.
// A good packet of N words emits its words one by one, each by a word store
// read, then an output load that waits while a result is undelivered; no byte
// is taken while words are emitted or a result waits.
// Reset: synchronous rst_n clears state, fields, CRC and counter; words are not.
module crc8_register_packet_deframer
  import crcdfr_pkg::*;
#(
  parameter int MAX_WORDS = 22
) (
  input  logic           clk,
  input  logic           rst_n,
  crcdfr_byte_if.sink    in_ch,
  crcdfr_res_if.source   out_ch
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  crcdfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  crcdfr_dp #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_byte   (in_ch.rx_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res       (res)
  );

  // Result fields onto the channel
  assign out_ch.status       = res.status;
  assign out_ch.op_code      = res.op_code;
  assign out_ch.page_number  = res.page_number;
  assign out_ch.start_offset = res.start_offset;
  assign out_ch.word_count   = res.word_count;
  assign out_ch.word_index   = res.word_index;
  assign out_ch.word_value   = res.word_value;
  assign out_ch.has_word     = res.has_word;
  assign out_ch.last         = res.last;
  assign out_ch.good_packets = res.good_packets;

endmodule

/* sv/crcdfr_ctrl.sv */
// Deframer controller: packet phase state machine and word emission sequencer.
// Depends on crcdfr_pkg; drives commands into crcdfr_dp.
module crcdfr_ctrl
  import crcdfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_HDR  = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_PAGE = 3'd2;
  localparam logic [2:0] S_OFF  = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_LD   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       parse;
  logic       fire;

  // Bytes are taken in the parse phases once the output slot is free
  assign parse    = (state_r != S_RD) && (state_r != S_LD);
  assign in_ready = parse && sts.out_free;
  assign fire     = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CHK: begin
        if (fire) begin
          cmd.ld_chk = 1'b1;
          state_nxt  = S_PAGE;
        end
      end
      S_PAGE: begin
        if (fire) begin
          cmd.ld_page = 1'b1;
          state_nxt   = S_OFF;
        end
      end
      S_OFF: begin
        if (fire) begin
          cmd.ld_off = 1'b1;
          if (sts.cnt_zero) begin
            state_nxt = S_HDR;
            if (sts.crc_bad) begin
              cmd.emit_crc_err = 1'b1;
            end else begin
              cmd.emit_empty = 1'b1;
              cmd.cnt_inc    = 1'b1;
            end
          end else begin
            state_nxt = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (fire) begin
          cmd.ld_data = 1'b1;
          if (sts.data_done) begin
            if (sts.crc_bad) begin
              cmd.emit_crc_err = 1'b1;
              state_nxt        = S_HDR;
            end else begin
              cmd.cnt_inc  = 1'b1;
              cmd.rd_start = 1'b1;
              state_nxt    = S_RD;
            end
          end
        end
      end
      S_RD: begin
        // word store read is in flight
        state_nxt = S_LD;
      end
      S_LD: begin
        if (sts.out_free) begin
          cmd.emit_word = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_HDR;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: begin
        // header byte; unused codes behave the same
        if (fire) begin
          if (sts.hdr_over) begin
            cmd.emit_hdr_err = 1'b1;
            state_nxt        = S_HDR;
          end else begin
            cmd.ld_hdr = 1'b1;
            state_nxt  = S_CHK;
          end
        end else begin
          state_nxt = S_HDR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HDR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/crcdfr_dp.sv */
// Deframer datapath: held header fields, running CRC, packet counter,
// word store memory and the result output register. Depends on crcdfr_pkg.
module crcdfr_dp
  import crcdfr_pkg::*;
#(
  parameter int MAX_WORDS = 22
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              res
);

  localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [CODE_W-1:0] code_r;
  logic [HCNT_W-1:0] count_r;
  logic [BYTE_W-1:0] chk_r;
  logic [BYTE_W-1:0] page_r;
  logic [BYTE_W-1:0] off_r;
  logic [BPOS_W-1:0] bpos_r;
  logic [BYTE_W-1:0] crc_r;
  logic [PKT_W-1:0]  pkt_cnt_r;
  logic [BYTE_W-1:0] lo_byte_r;
  logic [HCNT_W-1:0] emit_idx_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              out_valid_r;
  res_t              res_r, res_nxt;

  logic [WORD_W-1:0] mem [MAX_WORDS];

  logic [BYTE_W-1:0] crc_upd;
  logic [BPOS_W-1:0] bpos_inc;
  logic [BYTE_W-1:0] off_cur;
  logic              emit_any;
  logic              mem_we;

  // CRC over the current byte, shared by the page, offset and data phases
  assign crc_upd  = crc8_update(crc_r, rx_byte);
  assign bpos_inc = bpos_r + BPOS_W'(1);
  assign off_cur  = cmd.ld_off ? rx_byte : off_r;

  // Status toward the controller
  assign sts.hdr_over  = (32'(rx_byte[HCNT_W-1:0]) > 32'(MAX_WORDS));
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.data_done = (bpos_inc >= {count_r, 1'b0});
  assign sts.crc_bad   = (crc_upd != chk_r);
  assign sts.emit_last = ({1'b0, emit_idx_r} + BPOS_W'(1) == {1'b0, count_r});
  assign sts.out_free  = !out_valid_r || out_ready;

  // Header fields, CRC and byte position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r  <= '0;
      count_r <= '0;
      chk_r   <= '0;
      page_r  <= '0;
      off_r   <= '0;
      bpos_r  <= '0;
      crc_r   <= '0;
    end else begin
      if (cmd.ld_hdr) begin
        code_r  <= rx_byte[BYTE_W-1 -: CODE_W];
        count_r <= rx_byte[HCNT_W-1:0];
        crc_r   <= crc8_update('0, rx_byte);
      end
      if (cmd.ld_chk) begin
        chk_r <= rx_byte;
      end
      if (cmd.ld_page) begin
        page_r <= rx_byte;
        crc_r  <= crc_upd;
      end
      if (cmd.ld_off) begin
        off_r  <= rx_byte;
        crc_r  <= crc_upd;
        bpos_r <= '0;
      end
      if (cmd.ld_data) begin
        crc_r  <= crc_upd;
        bpos_r <= bpos_inc;
      end
    end
  end

  // Good packet counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      pkt_cnt_r <= pkt_cnt_r + PKT_W'(1);
    end
  end

  // Word store: low byte is held, whole word written on the high byte
  assign mem_we = cmd.ld_data && bpos_r[0];

  always_ff @(posedge clk) begin
    if (cmd.ld_data && !bpos_r[0]) begin
      lo_byte_r <= rx_byte;
    end
    if (mem_we) begin
      mem[bpos_r[IDX_W:1]] <= {rx_byte, lo_byte_r};
    end
    rd_data_r <= mem[emit_idx_r[IDX_W-1:0]];
  end

  // Emission word index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (cmd.rd_start) begin
      emit_idx_r <= '0;
    end else if (cmd.idx_inc) begin
      emit_idx_r <= emit_idx_r + HCNT_W'(1);
    end
  end

  // Result assembly
  always_comb begin
    res_nxt              = res_r;
    res_nxt.op_code      = code_r;
    res_nxt.page_number  = page_r;
    res_nxt.start_offset = off_cur;
    res_nxt.word_count   = count_r[WCNT_W-1:0];
    res_nxt.word_index   = '0;
    res_nxt.word_value   = '0;
    res_nxt.has_word     = 1'b0;
    res_nxt.last         = 1'b1;
    res_nxt.good_packets = pkt_cnt_r;
    res_nxt.status       = ST_GOOD;
    if (cmd.emit_hdr_err) begin
      res_nxt.status       = ST_CNT_OVER;
      res_nxt.op_code      = rx_byte[BYTE_W-1 -: CODE_W];
      res_nxt.page_number  = '0;
      res_nxt.start_offset = '0;
      res_nxt.word_count   = rx_byte[WCNT_W-1:0];
    end else if (cmd.emit_crc_err) begin
      res_nxt.status = ST_CRC_BAD;
    end else if (cmd.emit_empty) begin
      res_nxt.good_packets = pkt_cnt_r + PKT_W'(1);
    end else if (cmd.emit_word) begin
      res_nxt.word_index = emit_idx_r[WCNT_W-1:0];
      res_nxt.word_value = rd_data_r;
      res_nxt.has_word   = 1'b1;
      res_nxt.last       = sts.emit_last;
    end
  end

  assign emit_any = cmd.emit_hdr_err || cmd.emit_crc_err || cmd.emit_empty || cmd.emit_word;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_any) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_any) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  // A result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit_any |-> (!out_valid_r || out_ready))
    else $error("result loaded over an undelivered result");

  // At most one result source per cycle
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_hdr_err, cmd.emit_crc_err, cmd.emit_empty, cmd.emit_word}))
    else $error("several result sources at once");

  // Emitted words stay inside the packet
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_word |-> (emit_idx_r < count_r))
    else $error("word index beyond packet count");

  // Counter only ever steps by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pkt_cnt_r != $past(pkt_cnt_r)) |-> (pkt_cnt_r == $past(pkt_cnt_r) + PKT_W'(1)))
    else $error("packet counter jumped");

endmodule
